// File: rtl/preset_lift_position_controller_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the preset lift position controller
// Shared forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PRESET_LIFT_POSITION_CONTROLLER_TOP_ASSERT_SVH
`define PRESET_LIFT_POSITION_CONTROLLER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define PLPC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("plpc: same-cycle check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define PLPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("plpc: next-cycle check failed");

`endif

// File: rtl/plpc_pkg.sv
// ----------------------------------------------------------------------------
// plpc_pkg
// Types, register indexes and preset heights for the lift controller.
// ----------------------------------------------------------------------------
package plpc_pkg;

  localparam int IN_WIDTH  = 72;
  localparam int OUT_WIDTH = 56;

  localparam logic [2:0] REG_PRESET_SPEED    = 3'd0;
  localparam logic [2:0] REG_MANUAL_DEADBAND = 3'd1;
  localparam logic [2:0] REG_ARRIVE_WINDOW   = 3'd2;
  localparam logic [2:0] REG_BRAKE_THRESHOLD = 3'd3;
  localparam logic [2:0] REG_DEBOUNCE_TICKS  = 3'd4;

  localparam logic [2:0] TGT_NONE         = 3'd0;
  localparam logic [2:0] TGT_FLOOR        = 3'd1;
  localparam logic [2:0] TGT_LOW_SIDE     = 3'd2;
  localparam logic [2:0] TGT_LOW_CENTRE   = 3'd3;
  localparam logic [2:0] TGT_MID_SIDE     = 3'd4;
  localparam logic [2:0] TGT_MID_CENTRE   = 3'd5;
  localparam logic [2:0] TGT_HIGH_SIDE    = 3'd6;
  localparam logic [2:0] TGT_HIGH_CENTRE  = 3'd7;

  typedef struct packed {
    logic [14:0] preset_speed;
    logic [14:0] manual_deadband;
    logic [15:0] arrive_window;
    logic [14:0] brake_threshold;
    logic [3:0]  debounce_ticks;
  } cfg_t;

  typedef struct packed {
    logic               bottom_limit;
    logic signed [31:0] encoder_raw;
    logic signed [15:0] side_axis;
    logic               high_button;
    logic               mid_button;
    logic               low_button;
    logic               floor_button;
    logic signed [15:0] manual_axis;
  } item_t;

  typedef struct packed {
    logic [3:0]  press_count;
    logic [31:0] zero_offset;
    logic [2:0]  target;
    logic        ready;
    logic        zeroed;
  } state_t;

  typedef struct packed {
    logic signed [15:0] drive_cmd;
    logic               brake_release;
    logic               ready_flag;
    logic               zeroed_flag;
    logic signed [31:0] lift_height;
    logic [2:0]         target_code;
  } result_t;

  function automatic logic signed [17:0] preset_height(input logic [2:0] code);
    logic signed [17:0] h;
    case (code)
      TGT_MID_SIDE:    h = 18'sd1850;
      TGT_MID_CENTRE:  h = 18'sd3760;
      TGT_HIGH_SIDE:   h = 18'sd5080;
      TGT_HIGH_CENTRE: h = 18'sd8310;
      default:         h = 18'sd0;
    endcase
    return h;
  endfunction

endpackage

// File: rtl/plpc_core.sv
// ----------------------------------------------------------------------------
// plpc_core
// One control tick: debounce and zero, position, target latch, drive, brake.
// ----------------------------------------------------------------------------
module plpc_core #(
  parameter int COUNT_WIDTH = 32
) (
  input  plpc_pkg::item_t   item,
  input  plpc_pkg::state_t  state,
  input  plpc_pkg::cfg_t    cfg,
  output plpc_pkg::state_t  state_next,
  output plpc_pkg::result_t result
);

  localparam int CMP_WIDTH = (COUNT_WIDTH > 18) ? COUNT_WIDTH : 18;

  logic [3:0]                     count_inc;
  logic [31:0]                    offset;
  logic signed [33:0]             diff;
  logic signed [COUNT_WIDTH-1:0]  pos;
  logic signed [CMP_WIDTH-1:0]    pos_ext;
  logic signed [CMP_WIDTH-1:0]    lower;
  logic signed [CMP_WIDTH-1:0]    upper;
  logic signed [17:0]             height;
  logic signed [17:0]             hd_ext;
  logic [2:0]                     code_sel;
  logic [2:0]                     target;
  logic signed [16:0]             axis;
  logic signed [16:0]             md_ext;
  logic signed [16:0]             axis_half;
  logic signed [15:0]             speed;
  logic [15:0]                    mag;
  logic                           ready;
  logic signed [31:0]             height_out;

  always_comb begin
    state_next = state;

    count_inc = (state.press_count == 4'hF) ? 4'hF : state.press_count + 4'd1;
    offset    = state.zero_offset;
    if (item.bottom_limit) begin
      state_next.press_count = count_inc;
      state_next.zeroed      = 1'b1;
      if (count_inc >= cfg.debounce_ticks) begin
        offset = item.encoder_raw;
      end
    end else begin
      state_next.press_count = 4'd0;
    end
    state_next.zero_offset = offset;

    diff    = {{2{offset[31]}}, offset} - {{2{item.encoder_raw[31]}}, item.encoder_raw};
    pos     = COUNT_WIDTH'(diff);
    pos_ext = CMP_WIDTH'(pos);

    if (item.high_button) begin
      code_sel = plpc_pkg::TGT_HIGH_SIDE;
    end else if (item.mid_button) begin
      code_sel = plpc_pkg::TGT_MID_SIDE;
    end else if (item.low_button) begin
      code_sel = plpc_pkg::TGT_LOW_SIDE;
    end else if (item.floor_button) begin
      code_sel = plpc_pkg::TGT_FLOOR;
    end else begin
      code_sel = plpc_pkg::TGT_NONE;
    end
    if (code_sel > plpc_pkg::TGT_FLOOR && !item.side_axis[15]) begin
      code_sel = code_sel + 3'd1;
    end
    target = (item.side_axis != 16'sd0) ? code_sel : state.target;

    height = plpc_pkg::preset_height(target);
    hd_ext = signed'({2'b00, cfg.arrive_window});
    lower  = CMP_WIDTH'(height - hd_ext);
    upper  = CMP_WIDTH'(height + hd_ext);

    axis      = 17'sd0 - {item.manual_axis[15], item.manual_axis};
    md_ext    = signed'({2'b00, cfg.manual_deadband});
    axis_half = axis >>> 1;

    ready = state.ready;
    speed = 16'sd0;
    if (target != plpc_pkg::TGT_NONE) begin
      if (pos_ext < lower) begin
        speed = signed'({1'b0, cfg.preset_speed});
        ready = 1'b0;
      end else if (pos_ext > upper) begin
        speed = 16'sd0 - signed'({1'b0, cfg.preset_speed});
        ready = 1'b1;
      end else begin
        target = plpc_pkg::TGT_NONE;
        ready  = 1'b1;
      end
    end else begin
      if (axis >= md_ext) begin
        speed = (axis > 17'sd32767) ? 16'sh7FFF : axis[15:0];
        ready = 1'b0;
      end else if (axis <= 17'sd0 - md_ext) begin
        speed = axis_half[15:0];
        ready = 1'b0;
      end
    end
    state_next.target = target;
    state_next.ready  = ready;

    mag = speed[15] ? 16'd0 - speed : speed;

    result.drive_cmd     = speed;
    result.brake_release = mag > {1'b0, cfg.brake_threshold};
    result.ready_flag    = ready;
    result.zeroed_flag   = state_next.zeroed;
    result.lift_height   = height_out;
    result.target_code   = target;
  end

  if (COUNT_WIDTH > 32) begin : g_sat
    always_comb begin
      if (pos > COUNT_WIDTH'(33'sh0_7FFF_FFFF)) begin
        height_out = 32'sh7FFF_FFFF;
      end else if (pos < COUNT_WIDTH'(33'sh1_8000_0000)) begin
        height_out = 32'sh8000_0000;
      end else begin
        height_out = 32'(pos);
      end
    end
  end else begin : g_ext
    assign height_out = 32'(pos);
  end

endmodule

// File: rtl/preset_lift_position_controller_top.sv
// ----------------------------------------------------------------------------
// preset_lift_position_controller_top
// Usage: one input transfer per control tick on the s_ stream carries the
// bottom limit switch, encoder count, side axis, preset buttons and manual
// axis; each produces exactly one result transfer on the m_ stream with the
// motor command, brake release, ready, zeroed, lift height and target code.
// Configuration is written through cfg_wr_en / cfg_index / cfg_data while no
// transfer is in flight; indexes beyond the register list are ignored.
// Pipeline: an input transfer passes through the input register, then the
// result register, whose update raises m_tvalid. Throughput: one transfer
// per cycle while m_tready keeps the result moving, set by the state update
// between the two registers.
// Reset: synchronous rst clears both valid flags, the debounce count, the
// zero offset, the target, the ready and zeroed flags, and loads the
// register defaults.
// Stall: while m_tready is low the result is held and one further transfer
// is taken into the input register; then s_tready drops until the result
// moves on.
// ----------------------------------------------------------------------------
module preset_lift_position_controller_top #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  // bottom_limit, encoder_raw, side_axis, high_button, mid_button,
  // low_button, floor_button, manual_axis, zero pad
  input  logic [plpc_pkg::IN_WIDTH-1:0]  s_tdata,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // drive_cmd, brake_release, ready_flag, zeroed_flag, lift_height,
  // target_code, zero pad
  output logic [plpc_pkg::OUT_WIDTH-1:0] m_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic                           cfg_wr_en,
  input  logic [2:0]                     cfg_index,
  input  logic [15:0]                    cfg_data
);

  plpc_pkg::cfg_t    cfg;
  plpc_pkg::item_t   item_in;
  plpc_pkg::item_t   item;
  plpc_pkg::state_t  state;
  plpc_pkg::state_t  state_next;
  plpc_pkg::result_t result_next;
  plpc_pkg::result_t result;
  logic              item_valid;
  logic              advance;

  assign item_in.bottom_limit = s_tdata[0];
  assign item_in.encoder_raw  = s_tdata[32:1];
  assign item_in.side_axis    = s_tdata[48:33];
  assign item_in.high_button  = s_tdata[49];
  assign item_in.mid_button   = s_tdata[50];
  assign item_in.low_button   = s_tdata[51];
  assign item_in.floor_button = s_tdata[52];
  assign item_in.manual_axis  = s_tdata[68:53];

  assign advance  = item_valid && (!m_tvalid || m_tready);
  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.preset_speed    <= 15'd32767;
      cfg.manual_deadband <= 15'd3277;
      cfg.arrive_window   <= 16'd40;
      cfg.brake_threshold <= 15'd3277;
      cfg.debounce_ticks  <= 4'd5;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        plpc_pkg::REG_PRESET_SPEED:    cfg.preset_speed    <= cfg_data[14:0];
        plpc_pkg::REG_MANUAL_DEADBAND: cfg.manual_deadband <= cfg_data[14:0];
        plpc_pkg::REG_ARRIVE_WINDOW:   cfg.arrive_window   <= cfg_data;
        plpc_pkg::REG_BRAKE_THRESHOLD: cfg.brake_threshold <= cfg_data[14:0];
        plpc_pkg::REG_DEBOUNCE_TICKS:  cfg.debounce_ticks  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      m_tvalid   <= 1'b0;
      state      <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        item_valid <= 1'b1;
      end else if (advance) begin
        item_valid <= 1'b0;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
        state    <= state_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= item_in;
    end
    if (advance) begin
      result <= result_next;
    end
  end

  plpc_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .item       (item),
    .state      (state),
    .cfg        (cfg),
    .state_next (state_next),
    .result     (result_next)
  );

  assign m_tdata = {2'b00, result.target_code, result.lift_height, result.zeroed_flag,
                    result.ready_flag, result.brake_release, result.drive_cmd};

`include "preset_lift_position_controller_top_assert.svh"

  `PLPC_ASSERT_NEXT(a_zeroed_sticky, state.zeroed, state.zeroed)
  `PLPC_ASSERT_NEXT(a_release_clears_count, advance && !item.bottom_limit,
                    state.press_count == 4'd0)
  `PLPC_ASSERT_NOW(a_brake_needs_motion, m_tvalid && result.brake_release,
                   result.drive_cmd != 16'sd0)

endmodule

// File: tb/sv/lift_result_checker.sv
// ----------------------------------------------------------------------------
// Lift controller result checker
// Watches the input, result and register-write ports of the preset lift
// controller. Keeps its own copy of the debounce count, zero offset, target,
// ready and zeroed flags and the register file. For every input transfer it
// works out the expected result. Each result transfer is compared field by
// field against the oldest expected result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lift_result_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [plpc_pkg::IN_WIDTH-1:0]  s_tdata,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [plpc_pkg::OUT_WIDTH-1:0] m_tdata,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic                           cfg_wr_en,
  input  logic [2:0]                     cfg_index,
  input  logic [15:0]                    cfg_data,
  output int                             mismatches,
  output int                             pending
);

  localparam int SPEED_DEFAULT    = 32767;
  localparam int MANUAL_DB_DEFAULT = 3277;
  localparam int HEIGHT_DB_DEFAULT = 40;
  localparam int BRAKE_DEFAULT    = 3277;
  localparam int DEBOUNCE_DEFAULT = 5;

  int speed_cfg, manual_db_cfg, height_db_cfg, brake_cfg, debounce_cfg;

  logic [3:0]  press_q;
  logic [31:0] offset_q;
  logic [2:0]  target_q;
  logic        ready_q;
  logic        zeroed_q;

  plpc_pkg::result_t lift_results_due[$];
  int                fault_count;

  function automatic longint preset_lift_height(input logic [2:0] code);
    case (code)
      plpc_pkg::TGT_MID_SIDE:    return 1850;
      plpc_pkg::TGT_MID_CENTRE:  return 3760;
      plpc_pkg::TGT_HIGH_SIDE:   return 5080;
      plpc_pkg::TGT_HIGH_CENTRE: return 8310;
      default:                   return 0;
    endcase
  endfunction

  function automatic plpc_pkg::result_t next_lift_result(input plpc_pkg::item_t it);
    plpc_pkg::result_t  r;
    logic signed [31:0] pos;
    logic [2:0]         code;
    longint             h, axis, spd, mag;
    if (it.bottom_limit) begin
      if (press_q != 4'd15) press_q = press_q + 4'd1;
      if (press_q >= debounce_cfg) offset_q = it.encoder_raw;
      zeroed_q = 1'b1;
    end else begin
      press_q = 4'd0;
    end

    pos = offset_q - it.encoder_raw;

    if (it.side_axis != 0) begin
      if (it.high_button) code = plpc_pkg::TGT_HIGH_SIDE;
      else if (it.mid_button) code = plpc_pkg::TGT_MID_SIDE;
      else if (it.low_button) code = plpc_pkg::TGT_LOW_SIDE;
      else if (it.floor_button) code = plpc_pkg::TGT_FLOOR;
      else code = plpc_pkg::TGT_NONE;
      // centre preset sits one code above its side preset
      if (it.side_axis > 0 && code != plpc_pkg::TGT_NONE && code != plpc_pkg::TGT_FLOOR)
        code = code + 3'd1;
      target_q = code;
    end

    spd = 0;
    if (target_q != plpc_pkg::TGT_NONE) begin
      h = preset_lift_height(target_q);
      if (longint'(pos) < h - longint'(height_db_cfg)) begin
        spd = longint'(speed_cfg);
        ready_q = 1'b0;
      end else if (longint'(pos) > h + longint'(height_db_cfg)) begin
        spd = -longint'(speed_cfg);
        ready_q = 1'b1;
      end else begin
        target_q = plpc_pkg::TGT_NONE;
        ready_q = 1'b1;
      end
    end else begin
      axis = -longint'(it.manual_axis);
      if (axis >= longint'(manual_db_cfg)) begin
        spd = (axis > 32767) ? 32767 : axis;
        ready_q = 1'b0;
      end else if (axis <= -longint'(manual_db_cfg)) begin
        spd = axis >>> 1;
        ready_q = 1'b0;
      end
    end

    mag = (spd < 0) ? -spd : spd;
    r.drive_cmd     = spd[15:0];
    r.brake_release = (mag > longint'(brake_cfg));
    r.ready_flag    = ready_q;
    r.zeroed_flag   = zeroed_q;
    r.lift_height   = pos;
    r.target_code   = target_q;
    return r;
  endfunction

  function automatic void compare_field(input string field, input longint want,
                                        input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fault_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    plpc_pkg::item_t   it;
    plpc_pkg::result_t want, got;
    if (rst) begin
      speed_cfg     = SPEED_DEFAULT;
      manual_db_cfg = MANUAL_DB_DEFAULT;
      height_db_cfg = HEIGHT_DB_DEFAULT;
      brake_cfg     = BRAKE_DEFAULT;
      debounce_cfg  = DEBOUNCE_DEFAULT;
      press_q  = '0;
      offset_q = '0;
      target_q = plpc_pkg::TGT_NONE;
      ready_q  = 1'b0;
      zeroed_q = 1'b0;
      lift_results_due.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          plpc_pkg::REG_PRESET_SPEED:    speed_cfg     = int'(cfg_data[14:0]);
          plpc_pkg::REG_MANUAL_DEADBAND: manual_db_cfg = int'(cfg_data[14:0]);
          plpc_pkg::REG_ARRIVE_WINDOW:   height_db_cfg = int'(cfg_data);
          plpc_pkg::REG_BRAKE_THRESHOLD: brake_cfg     = int'(cfg_data[14:0]);
          plpc_pkg::REG_DEBOUNCE_TICKS:  debounce_cfg  = int'(cfg_data[3:0]);
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        it.bottom_limit = s_tdata[0];
        it.encoder_raw  = s_tdata[32:1];
        it.side_axis    = s_tdata[48:33];
        it.high_button  = s_tdata[49];
        it.mid_button   = s_tdata[50];
        it.low_button   = s_tdata[51];
        it.floor_button = s_tdata[52];
        it.manual_axis  = s_tdata[68:53];
        lift_results_due.push_back(next_lift_result(it));
      end
      if (m_tvalid && m_tready) begin
        got.drive_cmd     = m_tdata[15:0];
        got.brake_release = m_tdata[16];
        got.ready_flag    = m_tdata[17];
        got.zeroed_flag   = m_tdata[18];
        got.lift_height   = m_tdata[50:19];
        got.target_code   = m_tdata[53:51];
        if (lift_results_due.size() == 0) begin
          $error("result transfer with no result expected");
          fault_count++;
        end else begin
          want = lift_results_due.pop_front();
          compare_field("drive_cmd", want.drive_cmd, got.drive_cmd);
          compare_field("brake_release", want.brake_release, got.brake_release);
          compare_field("ready_flag", want.ready_flag, got.ready_flag);
          compare_field("zeroed_flag", want.zeroed_flag, got.zeroed_flag);
          compare_field("lift_height", want.lift_height, got.lift_height);
          compare_field("target_code", want.target_code, got.target_code);
        end
      end
    end
    mismatches <= fault_count;
    pending    <= lift_results_due.size();
  end

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Preset lift position controller testbench
// Drives control ticks into the controller: a directed run over manual drive
// edges, encoder extremes, debounced zeroing and every preset target, then
// random ticks under several register settings, with random input gaps and
// result-side stalls in all but the last two phases. A separate checker
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int PHASES       = 6;
  localparam int PHASE_TICKS  = 317;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_WAIT  = 4;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic [plpc_pkg::IN_WIDTH-1:0]  s_tdata = '0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [plpc_pkg::OUT_WIDTH-1:0] m_tdata;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic                           cfg_wr_en = 1'b0;
  logic [2:0]                     cfg_index = plpc_pkg::REG_PRESET_SPEED;
  logic [15:0]                    cfg_data = '0;

  int mismatches, pending;
  int cycles = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int manual_db_now = 3277;
  int height_db_now = 40;

  preset_lift_position_controller_top uut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lift_result_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic plpc_pkg::item_t make_tick(input logic bl, input int enc,
                                                input int side, input logic [3:0] btn,
                                                input int man);
    plpc_pkg::item_t t;
    t.bottom_limit = bl;
    t.encoder_raw  = enc;
    t.side_axis    = side[15:0];
    {t.high_button, t.mid_button, t.low_button, t.floor_button} = btn;
    t.manual_axis  = man[15:0];
    return t;
  endfunction

  task automatic send_tick(input plpc_pkg::item_t t);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= {3'b000, t.manual_axis, t.floor_button, t.low_button, t.mid_button,
                 t.high_button, t.side_axis, t.encoder_raw, t.bottom_limit};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic load_settings(input int spd, input int mdb, input int hdb,
                               input int brk, input int deb);
    cfg_wr_en <= 1'b1;
    cfg_index <= plpc_pkg::REG_PRESET_SPEED;    cfg_data <= spd[15:0]; @(posedge clk);
    cfg_index <= plpc_pkg::REG_MANUAL_DEADBAND; cfg_data <= mdb[15:0]; @(posedge clk);
    cfg_index <= plpc_pkg::REG_ARRIVE_WINDOW;   cfg_data <= hdb[15:0]; @(posedge clk);
    cfg_index <= plpc_pkg::REG_BRAKE_THRESHOLD; cfg_data <= brk[15:0]; @(posedge clk);
    cfg_index <= plpc_pkg::REG_DEBOUNCE_TICKS;  cfg_data <= deb[15:0]; @(posedge clk);
    cfg_wr_en <= 1'b0;
    manual_db_now = mdb;
    height_db_now = hdb;
  endtask

  // drain every outstanding result, then hold off for the pipeline
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  initial begin
    plpc_pkg::item_t t;
    int    heights[5] = '{0, 1850, 3760, 5080, 8310};
    int    base, press_left, pick, w, offs, mag;
    logic  [3:0] btn;

    base = 500;
    press_left = 0;
    send_gap_pct = 31;
    recv_stall_pct = 47;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // manual drive edges and encoder extremes, nothing zeroed yet
    send_tick(make_tick(1'b0, 0, 0, 4'b0000, -32768));
    send_tick(make_tick(1'b0, 0, 0, 4'b0000, 32767));
    send_tick(make_tick(1'b0, 32'sh7fffffff, 0, 4'b0000, 3277));
    send_tick(make_tick(1'b0, 32'sh80000000, 0, 4'b0000, -3277));
    send_tick(make_tick(1'b0, 0, 0, 4'b0000, -3276));
    // debounce, zero at 500, release
    repeat (6) send_tick(make_tick(1'b1, 500, 0, 4'b0000, 0));
    send_tick(make_tick(1'b0, 500, 0, 4'b0000, 0));
    // presets: drive up, arrive, drive down, arrive on the window edge
    send_tick(make_tick(1'b0, 500, 32767, 4'b1111, 0));
    send_tick(make_tick(1'b0, 500 - 8300, 0, 4'b0000, 0));
    send_tick(make_tick(1'b0, 500 - 9000, -32768, 4'b1000, 0));
    send_tick(make_tick(1'b0, 500 - 5120, 0, 4'b0000, 0));
    send_tick(make_tick(1'b0, 500, -1, 4'b0100, 0));
    send_tick(make_tick(1'b0, 500, 1, 4'b0100, 0));
    send_tick(make_tick(1'b0, 500, 5, 4'b0010, 0));
    send_tick(make_tick(1'b0, 500, -5, 4'b0010, 0));
    send_tick(make_tick(1'b0, 400, 7, 4'b0001, 0));
    send_tick(make_tick(1'b0, 500, 100, 4'b0000, 0));
    send_tick(make_tick(1'b0, 541, -3, 4'b0001, 0));
    send_tick(make_tick(1'b0, 541, 0, 4'b0000, 20000));

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: load_settings(32767, 3277, 40, 3277, 5);
        1: load_settings(0, 0, 0, 0, 1);
        2: load_settings(32767, 32767, 65535, 32767, 15);
        3: load_settings($urandom_range(0, 32767), $urandom_range(0, 8000),
                         $urandom_range(0, 400), $urandom_range(0, 32767), 0);
        4: load_settings($urandom_range(0, 32767), $urandom_range(0, 32767),
                         $urandom_range(0, 65535), $urandom_range(0, 32767),
                         $urandom_range(1, 15));
        default: load_settings($urandom_range(1000, 32767), $urandom_range(100, 6000),
                               $urandom_range(0, 8), $urandom_range(0, 20000),
                               $urandom_range(1, 15));
      endcase
      case (ph / 2)
        0: begin
          send_gap_pct = 31;
          recv_stall_pct = 47;
        end
        1: begin
          send_gap_pct = 47;
          recv_stall_pct = 31;
        end
        default: begin
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
      endcase

      repeat (PHASE_TICKS) begin
        // bottom switch runs, long ones move the zero
        if (press_left == 0 && $urandom_range(0, 99) < 8) begin
          press_left = $urandom_range(1, 18);
          if (press_left >= 15) base = $urandom_range(0, 200000) - 100000;
        end
        t = '0;
        t.bottom_limit = (press_left != 0);
        if (press_left != 0) press_left--;

        pick = $urandom_range(0, 99);
        w = height_db_now + 60;
        if (t.bottom_limit && pick < 80) begin
          t.encoder_raw = base;
        end else if (pick < 60) begin
          offs = $urandom_range(0, 2 * w);
          t.encoder_raw = base - (heights[$urandom_range(0, 4)] + offs - w);
        end else if (pick < 85) begin
          offs = $urandom_range(0, 20000);
          t.encoder_raw = base - (offs - 10000);
        end else begin
          t.encoder_raw = $urandom;
        end

        pick = $urandom_range(0, 99);
        if (pick < 45) t.side_axis = 0;
        else if (pick < 65) begin
          offs = $urandom_range(1, 3);
          t.side_axis = 16'($urandom_range(0, 1) ? -offs : offs);
        end
        else if (pick < 80) t.side_axis = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
        else t.side_axis = 16'($urandom);

        pick = $urandom_range(0, 99);
        if (pick < 40) btn = 4'b0001 << $urandom_range(0, 3);
        else if (pick < 55) btn = 4'b0000;
        else btn = 4'($urandom);
        {t.high_button, t.mid_button, t.low_button, t.floor_button} = btn;

        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          mag = manual_db_now + $urandom_range(0, 4) - 2;
          t.manual_axis = 16'($urandom_range(0, 1) ? -mag : mag);
        end
        else if (pick < 40) t.manual_axis = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
        else if (pick < 50) t.manual_axis = 0;
        else t.manual_axis = 16'($urandom);

        send_tick(t);
      end
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
